// File: src/gqls_pkg.sv
// Shared types and constants for the grid Q-learning step block.
package gqls_pkg;

  localparam int GRID_WIDTH_DEF  = 16;
  localparam int GRID_HEIGHT_DEF = 16;
  localparam int VALUE_BITS_DEF  = 40;

  localparam int LOAD_BITS  = 40;
  localparam int CELL_BITS  = 8;
  localparam int STEP_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int PCT_BITS   = 7;

  localparam logic [15:0] LEARN_RATE_RST = 16'd58982;
  localparam logic [15:0] DISCOUNT_RST   = 16'd58982;
  localparam logic [6:0]  EXPLORE_RST    = 7'd50;
  localparam logic [7:0]  GOAL_RST       = 8'd0;

  typedef enum logic [1:0] {
    CMD_LOAD_Q      = 2'd0,
    CMD_LOAD_REWARD = 2'd1,
    CMD_START       = 2'd2,
    CMD_STEP        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_DISCOUNT   = 2'd1,
    REG_EXPLORE    = 2'd2,
    REG_GOAL       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NORTH = 2'd0,
    ACT_SOUTH = 2'd1,
    ACT_EAST  = 2'd2,
    ACT_WEST  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_OLD,     // read four Q of current cell
    ST_PICK,       // choose action, compute move target
    ST_RD_NEW,     // read four Q and reward of new cell
    ST_GREEDY,     // greedy of new cell, gamma multiply
    ST_TARGET,     // target = reward + scaled, diff
    ST_ALPHA,      // alpha multiply
    ST_WRITE,      // write back updated Q
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic do_load;
    logic rd_old;
    logic pick;
    logic rd_new;
    logic greedy;
    logic target;
    logic alpha;
    logic write;
    logic finish_step;
    logic finish_other;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] cmd;
    logic       step_live;   // agent not at goal cell
    logic       out_free;    // result register empty or being taken
  } sts_t;

endpackage

// File: src/gqls_ctrl.sv
// Sequencing state machine for the grid Q-learning step block.
module gqls_ctrl import gqls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.cmd == CMD_STEP && sts.step_live) begin
          ctl.rd_old = 1'b1;
          state_next = ST_RD_OLD;
        end else if (sts.out_free) begin
          ctl.do_load      = 1'b1;
          ctl.finish_other = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_RD_OLD: begin ctl.pick = 1'b1;   state_next = ST_PICK;   end
      ST_PICK:   begin ctl.rd_new = 1'b1; state_next = ST_RD_NEW; end
      ST_RD_NEW: begin ctl.greedy = 1'b1; state_next = ST_GREEDY; end
      ST_GREEDY: begin ctl.target = 1'b1; state_next = ST_TARGET; end
      ST_TARGET: begin ctl.alpha = 1'b1;  state_next = ST_ALPHA;  end
      ST_ALPHA:  begin ctl.write = 1'b1;  state_next = ST_WRITE;  end
      ST_WRITE: begin
        if (sts.out_free) begin
          ctl.finish_step = 1'b1;
          state_next      = ST_DONE;
        end
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/gqls_dp.sv
// Datapath: stores, agent state, action choice and Q update arithmetic.
module gqls_dp import gqls_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  input  logic [1:0]             cmd,
  input  logic [CELL_BITS-1:0]   cell_req,
  input  logic [1:0]             action_slot,
  input  logic signed [LOAD_BITS-1:0] load_value,
  input  logic [PCT_BITS-1:0]    explore_draw,
  input  logic [1:0]             random_action,
  input  logic [15:0]            learn_rate,
  input  logic [15:0]            discount,
  input  logic [PCT_BITS-1:0]    explore_percent,
  input  logic [CELL_BITS-1:0]   goal_cell,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CELL_BITS-1:0]   position,
  output logic [1:0]             action_taken,
  output logic                   hit_wall,
  output logic                   at_goal,
  output logic [STEP_BITS-1:0]   step_count
);

  localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
  localparam int NCELLS     = (CELL_TOTAL < 256) ? CELL_TOTAL : 256;
  localparam int RA_BITS    = $clog2(NCELLS);
  localparam int VB         = VALUE_BITS;
  localparam int MAG_HI     = VB - FRAC_BITS;
  localparam int RECIP      = (65536 / GRID_HEIGHT) + 1;
  localparam logic [CELL_BITS-1:0] GH_M1 = CELL_BITS'(GRID_HEIGHT - 1);
  localparam logic [CELL_BITS-1:0] GW_M1 = CELL_BITS'(GRID_WIDTH - 1);
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  typedef logic signed [VB-1:0] val_t;

  // Four banks so all four actions of a cell are read in the same cycle.
  val_t q_mem0 [NCELLS];
  val_t q_mem1 [NCELLS];
  val_t q_mem2 [NCELLS];
  val_t q_mem3 [NCELLS];
  val_t r_mem  [NCELLS];

  logic [1:0]           cmd_r, slot_r, ract_r, act_r;
  logic [CELL_BITS-1:0] cell_r, pos, pos_next, tn_r;
  logic [PCT_BITS-1:0]  draw_r;
  val_t                 ld_r;
  logic [STEP_BITS-1:0] steps, steps_next;
  logic                 wall_r;
  logic                 finish;

  logic [RA_BITS-1:0]   rd_addr;
  val_t                 rq0, rq1, rq2, rq3, rr;
  val_t                 q_old, q_max, sc_g, target, diff, sc_a;

  function automatic logic [1:0] greedy_f(val_t n, val_t s, val_t e, val_t w);
    logic [1:0] r;
    if (n >= s) begin
      if (n > e) r = (n >= w) ? ACT_NORTH : ACT_WEST;
      else       r = (e > w)  ? ACT_EAST  : ACT_WEST;
    end else begin
      if (s >= e) r = (s > w) ? ACT_SOUTH : ACT_WEST;
      else        r = (e >= w) ? ACT_EAST : ACT_WEST;
    end
    return r;
  endfunction

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VB:0] s;
    s = {a[VB-1], a} + {b[VB-1], b};
    if (s[VB] != s[VB-1]) return s[VB] ? VMIN : VMAX;
    return s[VB-1:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [VB:0] s;
    s = {a[VB-1], a} - {b[VB-1], b};
    if (s[VB] != s[VB-1]) return s[VB] ? VMIN : VMAX;
    return s[VB-1:0];
  endfunction

  function automatic val_t load_sat(logic signed [LOAD_BITS-1:0] v);
    logic signed [63:0] x;
    x = 64'(v);
    if (x > 64'(VMAX)) return VMAX;
    if (x < 64'(VMIN)) return VMIN;
    return x[VB-1:0];
  endfunction

  // Move target; returns wall flag and cell.
  // Column comes from a reciprocal multiply, exact for 8-bit cell indexes.
  function automatic logic [CELL_BITS:0] move_f(logic [CELL_BITS-1:0] c, logic [1:0] a);
    logic [23:0]          prod;
    logic [CELL_BITS-1:0] col, row;
    logic [15:0]          t;
    logic                 w;
    prod = 24'(c) * 24'(RECIP);
    col  = prod[23:16];
    row  = c - CELL_BITS'(16'(col) * 16'(GRID_HEIGHT));
    w    = 1'b0;
    unique case (a)
      ACT_NORTH: if (row == GH_M1) w = 1'b1; else row = row + 1'b1;
      ACT_SOUTH: if (row == '0) w = 1'b1; else row = row - 1'b1;
      ACT_EAST:  if (col == GW_M1) w = 1'b1; else col = col + 1'b1;
      default:   if (col == '0) w = 1'b1; else col = col - 1'b1;
    endcase
    t = 16'(col) * 16'(GRID_HEIGHT) + 16'(row);
    if (t >= 16'(NCELLS)) w = 1'b1;
    if (w) return {1'b1, c};
    return {1'b0, t[CELL_BITS-1:0]};
  endfunction

  // Magnitude-based scaling by a Q0.16 factor, rounded half away from zero.
  // Two registered instances per step: gamma, then alpha.
  function automatic val_t scale_f(val_t v, logic [15:0] f);
    logic          neg;
    logic [VB-1:0] m;
    logic [VB-1:0] r;
    logic [MAG_HI+15:0] hi;
    logic [31:0]   lo;
    neg = v[VB-1];
    m   = neg ? (~v + 1'b1) : v;
    hi  = (MAG_HI+16)'(m[VB-1:FRAC_BITS]) * (MAG_HI+16)'(f);
    lo  = 32'(m[FRAC_BITS-1:0]) * 32'(f) + 32'h8000;
    r   = VB'(hi) + VB'(lo[31:16]);
    return neg ? val_t'(~r + 1'b1) : val_t'(r);
  endfunction

  logic [1:0] act_c;
  logic [CELL_BITS:0] mv;
  logic explore;

  assign explore = draw_r < explore_percent;
  assign act_c   = explore ? ract_r : greedy_f(rq0, rq1, rq2, rq3);
  assign mv      = move_f(pos, act_c);

  assign sts.cmd       = cmd_r;
  assign sts.step_live = (pos != goal_cell);
  assign sts.out_free  = !out_valid || out_ready;

  // Read address: old cell during first read, new cell after.
  assign rd_addr = ctl.rd_old ? RA_BITS'(pos) : RA_BITS'(tn_r);

  always_ff @(posedge clk) begin
    if (ctl.rd_old || ctl.rd_new) begin
      rq0 <= q_mem0[rd_addr];
      rq1 <= q_mem1[rd_addr];
      rq2 <= q_mem2[rd_addr];
      rq3 <= q_mem3[rd_addr];
      rr  <= r_mem[rd_addr];
    end
    if (ctl.do_load && cell_r < NCELLS) begin
      if (cmd_r == CMD_LOAD_REWARD) r_mem[RA_BITS'(cell_r)] <= ld_r;
      if (cmd_r == CMD_LOAD_Q) begin
        unique case (slot_r)
          ACT_NORTH: q_mem0[RA_BITS'(cell_r)] <= ld_r;
          ACT_SOUTH: q_mem1[RA_BITS'(cell_r)] <= ld_r;
          ACT_EAST:  q_mem2[RA_BITS'(cell_r)] <= ld_r;
          default:   q_mem3[RA_BITS'(cell_r)] <= ld_r;
        endcase
      end
    end
    if (ctl.write) begin
      unique case (act_r)
        ACT_NORTH: q_mem0[RA_BITS'(pos)] <= sat_add(q_old, sc_a);
        ACT_SOUTH: q_mem1[RA_BITS'(pos)] <= sat_add(q_old, sc_a);
        ACT_EAST:  q_mem2[RA_BITS'(pos)] <= sat_add(q_old, sc_a);
        default:   q_mem3[RA_BITS'(pos)] <= sat_add(q_old, sc_a);
      endcase
    end
  end

  // Payload and arithmetic registers.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd;
      cell_r <= cell_req;
      slot_r <= action_slot;
      ld_r   <= load_sat(load_value);
      draw_r <= explore_draw;
      ract_r <= random_action;
    end
    if (ctl.pick) begin
      act_r  <= act_c;
      wall_r <= mv[CELL_BITS];
      tn_r   <= mv[CELL_BITS-1:0];
      unique case (act_c)
        ACT_NORTH: q_old <= rq0;
        ACT_SOUTH: q_old <= rq1;
        ACT_EAST:  q_old <= rq2;
        default:   q_old <= rq3;
      endcase
    end
    if (ctl.greedy) begin
      sc_g <= scale_f(q_max, discount);
    end
    if (ctl.target) begin
      target <= sat_add(rr, sc_g);
    end
    if (ctl.alpha) begin
      sc_a <= scale_f(diff, learn_rate);
    end
  end

  always_comb begin
    unique case (greedy_f(rq0, rq1, rq2, rq3))
      ACT_NORTH: q_max = rq0;
      ACT_SOUTH: q_max = rq1;
      ACT_EAST:  q_max = rq2;
      default:   q_max = rq3;
    endcase
    diff = sat_sub(target, q_old);
  end

  // Next agent state.
  always_comb begin
    pos_next   = pos;
    steps_next = steps;
    if (ctl.finish_other && cmd_r == CMD_START) begin
      if (cell_r < NCELLS) pos_next = cell_r;
      steps_next = '0;
    end
    if (ctl.finish_step) begin
      pos_next = tn_r;
      if (steps != '1) steps_next = steps + 1'b1;
    end
  end

  assign finish = ctl.finish_other || ctl.finish_step;

  // Agent state and result register; the result register is separate from the
  // agent state so a waiting result does not block the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      steps        <= '0;
      out_valid    <= 1'b0;
      position     <= '0;
      action_taken <= '0;
      hit_wall     <= 1'b0;
      at_goal      <= 1'b0;
      step_count   <= '0;
    end else begin
      pos   <= pos_next;
      steps <= steps_next;
      if (finish) begin
        out_valid    <= 1'b1;
        position     <= pos_next;
        step_count   <= steps_next;
        at_goal      <= (pos_next == goal_cell) && (goal_cell < NCELLS);
        action_taken <= ctl.finish_step ? act_r : 2'b00;
        hit_wall     <= ctl.finish_step && wall_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/grid_q_learning_step_top.sv
// Top level of the grid Q-learning step block.
// Load, start and a step at the goal finish from state LOAD once the result register
// is free; a live step runs RD_OLD, PICK, RD_NEW, GREEDY, TARGET, ALPHA and WRITE
// (two Q reads, two dependent multiplies, write). One request is taken at a time;
// a result waiting in the output register holds back only the finish of the next one.
// Reset (rst, sync, high) clears position, step count, result; registers to defaults.
module grid_q_learning_step_top import gqls_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [CELL_BITS-1:0]   cell_req,
  input  logic [1:0]             action_slot,
  input  logic signed [LOAD_BITS-1:0] load_value,
  input  logic [PCT_BITS-1:0]    explore_draw,
  input  logic [1:0]             random_action,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CELL_BITS-1:0]   position,
  output logic [1:0]             action_taken,
  output logic                   hit_wall,
  output logic                   at_goal,
  output logic [STEP_BITS-1:0]   step_count,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  // Configuration registers.
  logic [15:0]          learn_rate, discount;
  logic [PCT_BITS-1:0]  explore_percent;
  logic [CELL_BITS-1:0] goal_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate      <= LEARN_RATE_RST;
      discount        <= DISCOUNT_RST;
      explore_percent <= EXPLORE_RST;
      goal_cell       <= GOAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARN_RATE: learn_rate      <= cfg_data;
        REG_DISCOUNT:   discount        <= cfg_data;
        REG_EXPLORE:    explore_percent <= cfg_data[PCT_BITS-1:0];
        default:        goal_cell       <= cfg_data[CELL_BITS-1:0];
      endcase
    end
  end

  ctl_t ctl;
  sts_t sts;

  gqls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  gqls_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cmd             (cmd),
    .cell_req        (cell_req),
    .action_slot     (action_slot),
    .load_value      (load_value),
    .explore_draw    (explore_draw),
    .random_action   (random_action),
    .learn_rate      (learn_rate),
    .discount        (discount),
    .explore_percent (explore_percent),
    .goal_cell       (goal_cell),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .position        (position),
    .action_taken    (action_taken),
    .hit_wall        (hit_wall),
    .at_goal         (at_goal),
    .step_count      (step_count)
  );

endmodule
